// ----- hw/rtl/bdpc_pkg.sv -----
package bdpc_pkg;

	// Bank size and the index width that addresses it
	localparam int NUM_BUTTONS = 6;
	localparam int IDX_W       = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;

	// Field widths
	localparam int BTN_W  = 3;
	localparam int TIME_W = 32;
	localparam int MS_W   = 16;

	// Configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_MS   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS_MS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_LEVEL  = 2'd2;

	localparam logic [MS_W-1:0] DEBOUNCE_MS_RST   = 16'd50;
	localparam logic [MS_W-1:0] LONG_PRESS_MS_RST = 16'd3000;
	localparam logic            ACTIVE_LEVEL_RST  = 1'b0;

	// Result flags of one poll
	typedef struct packed {
		logic pressed;
		logic released;
		logic short_press;
		logic long_press;
		logic held;
		logic stable_level;
	} poll_flags_t;

endpackage

// ----- hw/rtl/button_debounce_press_classifier_unit.sv -----
// Debounce and press classifier for a bank of push buttons. Every input beat is one
// poll of one button (index, raw pin level, millisecond time stamp, held-mode flag);
// every poll yields exactly one output beat of flags plus the button's debounced level.
// A raw level becomes the stable level once it has stayed unchanged for more than
// debounce_ms; presses and releases are flagged when accepted, a release flags a short
// press if no long press came and less than long_press_ms passed, and an active button
// flags a long press every time more than long_press_ms passes. Time differences wrap
// modulo 2^32. A poll of an index beyond the bank is dropped and returns all zeros.
// One poll per clock unless out_ready stalls; a poll passes the input register, then
// the result register. Per-button state is kept in flip-flops, read and written in the
// single cycle that moves a poll from the input register into the result register,
// so back-to-back polls of the same button always see each other's updates.
// Configuration registers are written through cfg_we/cfg_index/cfg_data at any edge
// and should only change while no poll is in flight.
module button_debounce_press_classifier_unit
	import bdpc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,

	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,

	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [BTN_W-1:0]      button,
	input  logic                  raw_level,
	input  logic [TIME_W-1:0]     now_ms,
	input  logic                  held_mode,

	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  pressed,
	output logic                  released,
	output logic                  short_press,
	output logic                  long_press,
	output logic                  held,
	output logic                  stable_level
);

	// Configuration registers
	logic [MS_W-1:0] debounce_ms_q;
	logic [MS_W-1:0] long_press_ms_q;
	logic            active_level_q;

	// Per-button state
	logic [NUM_BUTTONS-1:0] stable_q;
	logic [NUM_BUTTONS-1:0] last_raw_q;
	logic [NUM_BUTTONS-1:0] active_mark_q;
	logic [NUM_BUTTONS-1:0] long_mark_q;
	logic [TIME_W-1:0]      change_time_q [NUM_BUTTONS];
	logic [TIME_W-1:0]      press_time_q  [NUM_BUTTONS];

	// Input register stage
	logic                 valid_s1;
	logic [BTN_W-1:0]     button_s1;
	logic                 raw_s1;
	logic [TIME_W-1:0]    now_s1;
	logic                 held_mode_s1;

	// Result register stage
	logic                 valid_s2;
	poll_flags_t          flags_s2;

	// Handshake: the input stage advances whenever the result register is free or
	// being emptied; a waiting result holds the input register, and once that is
	// full the input too.
	logic advance;
	logic in_accept;

	assign advance   = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign in_accept = in_valid && in_ready;

	// Poll evaluation on the state of the button held in the input stage
	logic              in_range;
	logic [IDX_W-1:0]  idx;
	logic              is_active;
	logic              take_held;
	logic              cur_stable;
	logic              cur_last_raw;
	logic              cur_active_mark;
	logic              cur_long_mark;
	logic [TIME_W-1:0] cur_change_time;
	logic [TIME_W-1:0] cur_press_time;
	logic [TIME_W-1:0] since_press;
	logic [TIME_W-1:0] new_change_time;
	logic [TIME_W-1:0] since_change;
	logic              fire_long;
	logic              settle;
	logic              fire_short;
	logic              upd;
	poll_flags_t       flags;
	logic              nxt_stable;
	logic              nxt_active_mark;
	logic              nxt_long_mark;
	logic [TIME_W-1:0] nxt_press_time;

	always_comb begin
		in_range        = 32'(button_s1) < NUM_BUTTONS;
		idx             = IDX_W'(button_s1);
		is_active       = (raw_s1 == active_level_q);
		take_held       = held_mode_s1 && is_active;

		cur_stable      = stable_q[idx];
		cur_last_raw    = last_raw_q[idx];
		cur_active_mark = active_mark_q[idx];
		cur_long_mark   = long_mark_q[idx];
		cur_change_time = change_time_q[idx];
		cur_press_time  = press_time_q[idx];

		// Long press: repeat every long period while the button stays active
		since_press = now_s1 - cur_press_time;
		fire_long   = cur_active_mark && is_active &&
			(since_press > TIME_W'(long_press_ms_q));

		// Restart the debounce window on any raw edge
		new_change_time = (raw_s1 != cur_last_raw) ? now_s1 : cur_change_time;
		since_change    = now_s1 - new_change_time;
		settle          = (since_change > TIME_W'(debounce_ms_q)) && (raw_s1 != cur_stable);

		// A release never coincides with a long press, so the stored press time
		// and long mark are the right ones here
		fire_short = (since_press < TIME_W'(long_press_ms_q)) && !cur_long_mark;

		nxt_stable      = cur_stable;
		nxt_active_mark = cur_active_mark;
		nxt_long_mark   = cur_long_mark;
		nxt_press_time  = cur_press_time;
		flags           = '0;

		if (fire_long) begin
			nxt_press_time = now_s1;
			nxt_long_mark  = 1'b1;
			flags.long_press = 1'b1;
		end
		if (settle) begin
			nxt_stable = raw_s1;
			if (is_active) begin
				nxt_active_mark = 1'b1;
				nxt_press_time  = now_s1;
				flags.pressed   = 1'b1;
			end else begin
				nxt_active_mark   = 1'b0;
				nxt_long_mark     = 1'b0;
				flags.released    = 1'b1;
				flags.short_press = fire_short;
			end
		end
		flags.stable_level = nxt_stable;

		// Held mode with an active level reports held and touches nothing
		if (take_held) begin
			flags              = '0;
			flags.held         = 1'b1;
			flags.stable_level = cur_stable;
		end
		if (!in_range) begin
			flags = '0;
		end

		upd = advance && in_range && !take_held;
	end

	// Configuration writes; indexes beyond the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_ms_q   <= DEBOUNCE_MS_RST;
			long_press_ms_q <= LONG_PRESS_MS_RST;
			active_level_q  <= ACTIVE_LEVEL_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DEBOUNCE_MS:   debounce_ms_q   <= cfg_data;
				REG_LONG_PRESS_MS: long_press_ms_q <= cfg_data;
				REG_ACTIVE_LEVEL:  active_level_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Per-button state update, at the edge that moves the poll into the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stable_q      <= '1;
			last_raw_q    <= '1;
			active_mark_q <= '0;
			long_mark_q   <= '0;
			for (int k = 0; k < NUM_BUTTONS; k++) begin
				change_time_q[k] <= '0;
				press_time_q[k]  <= '0;
			end
		end else if (upd) begin
			stable_q[idx]      <= nxt_stable;
			last_raw_q[idx]    <= raw_s1;
			active_mark_q[idx] <= nxt_active_mark;
			long_mark_q[idx]   <= nxt_long_mark;
			change_time_q[idx] <= new_change_time;
			press_time_q[idx]  <= nxt_press_time;
		end
	end

	// Input register: hold the beat until it can advance
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			button_s1    <= button;
			raw_s1       <= raw_level;
			now_s1       <= now_ms;
			held_mode_s1 <= held_mode;
		end
	end

	// Result register: hold the result until the consumer takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			flags_s2 <= flags;
		end
	end

	assign out_valid    = valid_s2;
	assign pressed      = flags_s2.pressed;
	assign released     = flags_s2.released;
	assign short_press  = flags_s2.short_press;
	assign long_press   = flags_s2.long_press;
	assign held         = flags_s2.held;
	assign stable_level = flags_s2.stable_level;

`ifndef SYNTHESIS
	a_press_xor_release: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(pressed && released))
		else $error("press and release flagged on one poll");

	a_held_alone: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && held |-> !(pressed || released || short_press || long_press))
		else $error("held reported together with another flag");

	a_short_needs_release: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && short_press |-> released)
		else $error("short press without release");

	a_long_not_release: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && long_press |-> !released)
		else $error("long press on a releasing poll");

	a_press_level: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && pressed |-> (stable_level == active_level_q))
		else $error("press accepted but stable level is not the active level");
`endif

endmodule
